// ----- hw/rtl/lpms_pkg.sv -----
// Shared types and constants of the longest prefix match selector.
// No dependencies; used by lpms_ctrl, lpms_datapath and the top level.
`default_nettype none

package lpms_pkg;

   // Item kinds on the request channel
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Address families
   localparam logic FAMILY_IPV4 = 1'b0;

   // Compare length limits per family
   localparam logic [7:0] V4_LIMIT = 8'd32;
   localparam logic [7:0] V6_LIMIT = 8'h80;

   // Cap on results per lookup
   localparam int MAX_OUT = 32;
   localparam int EMIT_W  = $clog2(MAX_OUT);

   // Request item
   typedef struct packed {
      logic        kind;
      logic [4:0]  entry_index;
      logic        entry_valid;
      logic        family;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [7:0]  prefix_len;
   } req_type;

   // Result item
   typedef struct packed {
      logic       found;
      logic [4:0] hit_index;
      logic [7:0] match_len;
      logic       last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic write;      // store the request as a table entry
      logic start;      // capture lookup key, clear best tracking
      logic issue;      // read the entry at the scan index into the score pipe
      logic load_hit;   // load a found result for the scan index
      logic load_miss;  // load the not-found result
      logic last;       // last flag of a found result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;        // entry at the scan index reaches the best score
      logic last_hit;   // scan index is the final entry at the best score
      logic found;      // some entry of the family was scored
      logic out_free;   // output register can take an item this cycle
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lpms_datapath.sv -----
// Datapath: entry table memory, valid bits, scoring pipeline, best tracking
// and the result output register. Depends on lpms_pkg.
`default_nettype none

module lpms_datapath #(
   parameter int TABLE_DEPTH = 32,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire                      clock,
   input  wire                      reset,
   input  lpms_pkg::req_type        req_data,
   input  lpms_pkg::cmd_type        cmd,
   input  wire [IDX_W-1:0]          scan_idx,
   output lpms_pkg::status_type     status,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output lpms_pkg::rsp_type        rsp_data
);

   localparam int WIDE_W = (IDX_W > 5) ? IDX_W : 5;
   localparam logic [8:0] DEPTH_9 = 9'(TABLE_DEPTH);

   // leading zeros of one byte, 0..8
   function automatic logic [3:0] lz8(input logic [7:0] v);
      logic [3:0] n;
      logic       done;
      n    = 4'd0;
      done = 1'b0;
      for (int j = 7; j >= 0; j--) begin
         if (!done) begin
            if (v[j]) begin
               done = 1'b1;
            end else begin
               n = n + 4'd1;
            end
         end
      end
      return n;
   endfunction

   // join four byte counts, MSB byte first, into a 32-bit count
   function automatic logic [5:0] join8(input logic [3:0] c0, input logic [3:0] c1,
                                        input logic [3:0] c2, input logic [3:0] c3);
      logic [3:0] c [4];
      logic [5:0] n;
      logic       done;
      c[0] = c0; c[1] = c1; c[2] = c2; c[3] = c3;
      n    = 6'd0;
      done = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!done) begin
            n = n + 6'(c[k]);
            if (c[k] != 4'd8) done = 1'b1;
         end
      end
      return n;
   endfunction

   // join four word counts into a 128-bit count
   function automatic logic [7:0] join32(input logic [5:0] c0, input logic [5:0] c1,
                                         input logic [5:0] c2, input logic [5:0] c3);
      logic [5:0] c [4];
      logic [7:0] n;
      logic       done;
      c[0] = c0; c[1] = c1; c[2] = c2; c[3] = c3;
      n    = 8'd0;
      done = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!done) begin
            n = n + 8'(c[k]);
            if (c[k] != 6'd32) done = 1'b1;
         end
      end
      return n;
   endfunction

   // entry table storage
   logic [63:0]            table_hi_ff  [TABLE_DEPTH];
   logic [63:0]            table_lo_ff  [TABLE_DEPTH];
   logic [7:0]             table_pfx_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] family_ff;

   // lookup key
   logic [63:0] key_hi_ff;
   logic [63:0] key_lo_ff;
   logic [7:0]  key_len_ff;
   logic        key_fam_ff;

   // write address and range check
   logic [WIDE_W-1:0] wr_wide;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_en;

   assign wr_wide = WIDE_W'(req_data.entry_index);
   assign wr_addr = wr_wide[IDX_W-1:0];
   assign wr_en   = cmd.write && (9'(req_data.entry_index) < DEPTH_9);

   // table write and registered read
   logic [63:0]      rd_hi_ff;
   logic [63:0]      rd_lo_ff;
   logic [7:0]       rd_pfx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_hi_ff[wr_addr]  <= req_data.address_high;
         table_lo_ff[wr_addr]  <= req_data.address_low;
         table_pfx_ff[wr_addr] <= req_data.prefix_len;
      end
      rd_hi_ff  <= table_hi_ff[scan_idx];
      rd_lo_ff  <= table_lo_ff[scan_idx];
      rd_pfx_ff <= table_pfx_ff[scan_idx];
   end

   // valid bits cleared at reset, family travels with them
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= req_data.entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         family_ff[wr_addr] <= req_data.family;
      end
   end

   // key capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_hi_ff  <= req_data.address_high;
         key_lo_ff  <= req_data.address_low;
         key_len_ff <= req_data.prefix_len;
         key_fam_ff <= req_data.family;
      end
   end

   // score pipeline tags
   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic             s1_vld_in;

   assign s1_vld_in = cmd.issue && valid_ff[scan_idx] && (family_ff[scan_idx] == key_fam_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= scan_idx;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_idx_ff <= s3_idx_ff;
   end

   // stage 2: difference, per-byte leading zeros, compare limit
   logic [127:0] diff;
   logic [7:0]   lim_min;
   logic [7:0]   lim_in;
   logic [3:0]   s2_lz8_ff [16];
   logic [7:0]   s2_lim_ff;

   assign diff    = {rd_hi_ff, rd_lo_ff} ^ {key_hi_ff, key_lo_ff};
   assign lim_min = (rd_pfx_ff < key_len_ff) ? rd_pfx_ff : key_len_ff;

   always_comb begin
      lim_in = lim_min;
      if (key_fam_ff == lpms_pkg::FAMILY_IPV4) begin
         if (lim_min > lpms_pkg::V4_LIMIT) lim_in = lpms_pkg::V4_LIMIT;
      end else if (lim_min > lpms_pkg::V6_LIMIT) begin
         lim_in = lpms_pkg::V6_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 16; k++) begin
         s2_lz8_ff[k] <= lz8(diff[127-8*k -: 8]);
      end
      s2_lim_ff <= lim_in;
   end

   // stage 3: per 32-bit word counts
   logic [5:0] s3_lz32_ff [4];
   logic [7:0] s3_lim_ff;

   always_ff @(posedge clock) begin
      for (int g = 0; g < 4; g++) begin
         s3_lz32_ff[g] <= join8(s2_lz8_ff[4*g], s2_lz8_ff[4*g+1],
                                s2_lz8_ff[4*g+2], s2_lz8_ff[4*g+3]);
      end
      s3_lim_ff <= s2_lim_ff;
   end

   // stage 4: full count clipped to the limit
   logic [7:0] lz128;
   logic [7:0] s4_score_ff;

   assign lz128 = join32(s3_lz32_ff[0], s3_lz32_ff[1], s3_lz32_ff[2], s3_lz32_ff[3]);

   always_ff @(posedge clock) begin
      s4_score_ff <= (lz128 < s3_lim_ff) ? lz128 : s3_lim_ff;
   end

   // best score tracking and set of entries at the best score
   logic [7:0]             best_ff;
   logic [TABLE_DEPTH-1:0] hit_ff;
   logic [IDX_W-1:0]       last_ff;
   logic                   found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         best_ff  <= 8'd0;
         hit_ff   <= '0;
      end else if (cmd.start) begin
         found_ff <= 1'b0;
         best_ff  <= 8'd0;
         hit_ff   <= '0;
      end else if (s4_vld_ff) begin
         found_ff <= 1'b1;
         if (!found_ff || (s4_score_ff > best_ff)) begin
            // new best: this entry alone
            best_ff <= s4_score_ff;
            hit_ff  <= TABLE_DEPTH'(1'b1) << s4_idx_ff;
         end else if (s4_score_ff == best_ff) begin
            hit_ff[s4_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_vld_ff && (!found_ff || (s4_score_ff >= best_ff))) begin
         last_ff <= s4_idx_ff;
      end
   end

   // output register
   logic                  rsp_valid_ff;
   lpms_pkg::rsp_type     rsp_data_ff;
   logic [WIDE_W-1:0]     hit_wide;

   assign hit_wide = WIDE_W'(scan_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_hit || cmd.load_miss) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_hit) begin
         rsp_data_ff.found     <= 1'b1;
         rsp_data_ff.hit_index <= hit_wide[4:0];
         rsp_data_ff.match_len <= best_ff;
         rsp_data_ff.last      <= cmd.last;
      end else if (cmd.load_miss) begin
         rsp_data_ff.found     <= 1'b0;
         rsp_data_ff.hit_index <= 5'd0;
         rsp_data_ff.match_len <= 8'd0;
         rsp_data_ff.last      <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status back to the controller
   assign status.hit      = hit_ff[scan_idx];
   assign status.last_hit = (last_ff == scan_idx);
   assign status.found    = found_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

// ----- hw/rtl/lpms_ctrl.sv -----
// Controller: sequences table writes, the scoring scan, the drain of the
// score pipeline and the emit scan. Depends on lpms_pkg.
`default_nettype none

module lpms_ctrl #(
   parameter int TABLE_DEPTH = 32,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_kind,
   output logic                     req_stall,
   input  lpms_pkg::status_type     status,
   output lpms_pkg::cmd_type        cmd,
   output logic [IDX_W-1:0]         scan_idx
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   // cycles from the final read until best tracking has settled
   localparam logic [2:0] DRAIN_LAST = 3'd4;
   localparam logic [lpms_pkg::EMIT_W-1:0] EMIT_CAP =
      lpms_pkg::EMIT_W'(lpms_pkg::MAX_OUT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCORE = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_MISS  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [2:0]                    drain_ff, drain_in;
   logic [lpms_pkg::EMIT_W-1:0]   emitted_ff, emitted_in;
   logic                          accept;
   logic                          emit_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign emit_last = status.last_hit || (emitted_ff == EMIT_CAP);
   assign scan_idx  = idx_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      drain_in   = drain_ff;
      emitted_in = emitted_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == lpms_pkg::KIND_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  idx_in    = '0;
                  state_in  = ST_SCORE;
               end
            end
         end
         ST_SCORE: begin
            cmd.issue = 1'b1;
            if (idx_ff == LAST_IDX) begin
               drain_in = 3'd0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               idx_in     = '0;
               emitted_in = '0;
               state_in   = status.found ? ST_EMIT : ST_MISS;
            end else begin
               drain_in = drain_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            if (!status.hit) begin
               idx_in = idx_ff + 1'b1;
            end else if (status.out_free) begin
               cmd.load_hit = 1'b1;
               cmd.last     = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  emitted_in = emitted_ff + 1'b1;
               end
            end
         end
         ST_MISS: begin
            if (status.out_free) begin
               cmd.load_miss = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         drain_ff   <= 3'd0;
         emitted_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         drain_ff   <= drain_in;
         emitted_ff <= emitted_in;
      end
   end

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_hit || cmd.load_miss) |-> status.out_free)
      else $error("result loaded while output register is held");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      ((cmd.load_hit && cmd.last) || cmd.load_miss) |=> (state_ff == ST_IDLE))
      else $error("lookup did not end after its last result");

   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MISS) |-> !status.found)
      else $error("not-found result while an entry was scored");

   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> ((state_ff == ST_SCORE) && (idx_ff == '0)))
      else $error("lookup scan did not start at entry zero");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/longest_prefix_match_select.sv -----
// Top level of the longest prefix match selector: controller plus datapath.
// Depends on lpms_pkg, lpms_ctrl and lpms_datapath.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one item at a time.
//   A write item (kind 0) stores one table entry in its cycle and gives no
//   result; a slot at or beyond TABLE_DEPTH is ignored.
//   A lookup item (kind 1) scores every valid entry of the requested family
//   and returns, on the rsp channel, one item per entry at the best score in
//   index order, the final one flagged last (at most 32 items). With no
//   valid entry of the family it returns a single item with found clear.
// Operation:
//   A lookup accepts the item, reads every table slot in index order into
//   the four-stage scoring pipeline, drains that pipeline, then runs the
//   emit scan up to the last hit, one table slot per cycle while the output
//   is not stalled. The table memory read port sets the scan rate.
//   Writes leave req_stall low; it is high while a lookup is in progress.
// Reset and stall:
//   Synchronous reset invalidates all table entries at once; no clearing pass.
//   A stalled result is held in the output register and the emit scan waits;
//   a new request is taken as soon as the last result is registered.
`default_nettype none

module longest_prefix_match_select #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  lpms_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output lpms_pkg::rsp_type    rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   lpms_pkg::cmd_type    cmd;
   lpms_pkg::status_type status;
   logic [IDX_W-1:0]     scan_idx;

   // sequencing
   lpms_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   // table, scoring and output register
   lpms_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .scan_idx  (scan_idx),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
